/* sv/fpba_pkg.sv */
// fpba_pkg: shared types and constants of the fixed-priority budget admission block
// request and status codes, controller states, datapath operations, status bundle
// no dependencies
`default_nettype none

package fpba_pkg;

    localparam int MAX_SERVERS_DEF = 16;
    localparam int TICK_WIDTH_DEF  = 32;

    typedef enum logic [1:0] {
        REQ_ADD    = 2'd0,
        REQ_CHANGE = 2'd1,
        REQ_SET    = 2'd2,
        REQ_REPORT = 2'd3
    } req_type_t;

    localparam logic [1:0] STS_OK      = 2'd0;
    localparam logic [1:0] STS_UNKNOWN = 2'd1;
    localparam logic [1:0] STS_FULL    = 2'd2;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_LATCH,
        OP_RD_K,
        OP_K_INC,
        OP_SEL_K,
        OP_SEL_CNT,
        OP_RD_KM1,
        OP_SHIFT_WR,
        OP_ADD_WR,
        OP_EMIT_ADD_FULL,
        OP_EMIT_ADD,
        OP_CHG_HIT,
        OP_EMIT_CHG_UNK,
        OP_TRY_START,
        OP_RT_RD,
        OP_RT_LOAD,
        OP_RT_ITER,
        OP_RD_J,
        OP_ARITH_START,
        OP_RT_ACC,
        OP_I_INC,
        OP_TRY_OK,
        OP_TRY_FAIL,
        OP_CHG_WR,
        OP_EMIT_CHG,
        OP_SET_RD,
        OP_SET_WR,
        OP_EMIT_SET_UNK,
        OP_EMIT_SET,
        OP_RPT_START,
        OP_EMIT_RPT_EMPTY,
        OP_EMIT_RPT
    } dp_op_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISPATCH,
        S_ADD_FULL,
        S_ADD_SCAN,
        S_ADD_CMP,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_ADD_WR,
        S_ADD_EMIT,
        S_CHG_SCAN,
        S_CHG_CMP,
        S_CHG_UNK,
        S_SRCH,
        S_TRY_NEXT,
        S_RT_LOAD,
        S_RT_ITER,
        S_RT_J,
        S_RT_ARG,
        S_RT_WAIT,
        S_RT_CHK,
        S_CHG_WR,
        S_CHG_EMIT,
        S_SET_RD,
        S_SET_WR,
        S_SET_EMIT,
        S_SET_UNK,
        S_RPT_EMPTY,
        S_RPT_START,
        S_RPT_NEXT,
        S_RPT_EMIT
    } ctrl_state_t;

    typedef struct packed {
        req_type_t req;
        logic      full;
        logic      empty;
        logic      k_at_cnt;
        logic      k_at_sel;
        logic      per_gt;
        logic      tag_eq;
        logic      pos_bad;
        logic      search_done;
        logic      i_at_cnt;
        logic      j_at_i;
        logic      arith_done;
        logic      iter_more;
        logic      rt_fail;
        logic      rpt_last;
        logic      out_free;
    } dp_status_t;

endpackage

`default_nettype wire

/* sv/fpba_ram.sv */
// fpba_ram: generic single-port-write, single-port-read ram with registered read
// no dependencies
`default_nettype none

module fpba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* sv/fpba_arith.sv */
// fpba_arith: serial interference term unit, ceil(a / d) * q saturated
// restoring divide one bit a cycle, then shift-add multiply one bit a cycle
// no package dependencies
`default_nettype none

module fpba_arith #(
    parameter int TW = 32
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [TW-1:0] dividend,
    input  wire logic [TW-1:0] divisor,
    input  wire logic [TW-1:0] mult,
    output logic               done,
    output logic      [TW-1:0] term
);

    localparam int SCW = $clog2(TW + 1);

    typedef enum logic [1:0] {
        A_IDLE,
        A_DIV,
        A_FIX,
        A_MUL
    } arith_phase_t;

    arith_phase_t     phase_reg, phase_next;
    logic             done_reg, done_next;
    logic [SCW-1:0]   step_reg, step_next;
    logic [TW-1:0]    quo_reg, quo_next;
    logic [TW-1:0]    rem_reg, rem_next;
    logic [TW-1:0]    d_reg, d_next;
    logic [TW-1:0]    q_reg, q_next;
    logic [TW-1:0]    hi_reg, hi_next;
    logic [TW:0]      rem_sh;
    logic [TW:0]      rem_sub;
    logic [TW:0]      mac;
    logic             step_end;

    assign rem_sh   = {rem_reg, quo_reg[TW-1]};
    assign rem_sub  = rem_sh - {1'b0, d_reg};
    assign mac      = {1'b0, hi_reg} + (quo_reg[0] ? {1'b0, q_reg} : {(TW + 1){1'b0}});
    assign step_end = (step_reg == SCW'(TW - 1));

    always_comb
    begin
        phase_next = phase_reg;
        done_next  = done_reg;
        step_next  = step_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        d_next     = d_reg;
        q_next     = q_reg;
        hi_next    = hi_reg;
        if (start)
        begin
            phase_next = A_DIV;
            done_next  = 1'b0;
            step_next  = '0;
            quo_next   = dividend;
            rem_next   = '0;
            d_next     = divisor;
            q_next     = mult;
        end
        else
        begin
            case (phase_reg)
                A_DIV:
                begin
                    if (rem_sh >= {1'b0, d_reg})
                    begin
                        rem_next = rem_sub[TW-1:0];
                        quo_next = {quo_reg[TW-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_next = rem_sh[TW-1:0];
                        quo_next = {quo_reg[TW-2:0], 1'b0};
                    end
                    step_next = step_reg + SCW'(1);
                    if (step_end)
                    begin
                        phase_next = A_FIX;
                    end
                end
                A_FIX:
                begin
                    // round the quotient up, then reuse it as the multiplier
                    quo_next   = quo_reg + TW'(rem_reg != '0);
                    hi_next    = '0;
                    step_next  = '0;
                    phase_next = A_MUL;
                end
                A_MUL:
                begin
                    hi_next   = mac[TW:1];
                    quo_next  = {mac[0], quo_reg[TW-1:1]};
                    step_next = step_reg + SCW'(1);
                    if (step_end)
                    begin
                        phase_next = A_IDLE;
                        done_next  = 1'b1;
                    end
                end
                default:
                begin
                    phase_next = A_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= A_IDLE;
            done_reg  <= 1'b0;
            step_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            done_reg  <= done_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        d_reg   <= d_next;
        q_reg   <= q_next;
        hi_reg  <= hi_next;
    end

    assign done = done_reg;
    assign term = (hi_reg != '0) ? {TW{1'b1}} : quo_reg;

endmodule

`default_nettype wire

/* sv/fpba_dp.sv */
// fpba_dp: datapath of the admission block, server table, analysis registers, result register
// uses fpba_pkg, fpba_ram and fpba_arith
`default_nettype none

module fpba_dp
    import fpba_pkg::*;
#(
    parameter int MAX_SERVERS = MAX_SERVERS_DEF,
    parameter int TICK_WIDTH  = TICK_WIDTH_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire dp_op_t             op,
    output dp_status_t              sts,
    input  wire logic [1:0]         req_type,
    input  wire logic [7:0]         server_tag,
    input  wire logic [3:0]         position,
    input  wire logic [31:0]        period,
    input  wire logic [31:0]        budget,
    input  wire logic signed [31:0] budget_delta,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [1:0]              status,
    output logic [3:0]              position_res,
    output logic [7:0]              server_tag_res,
    output logic [31:0]             response_time,
    output logic signed [32:0]      granted_delta,
    output logic                    last
);

    localparam int TW = TICK_WIDTH;
    localparam int AW = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
    localparam int CW = $clog2(MAX_SERVERS + 1);
    localparam int RW = 8 + 2 * TW;
    localparam int SW = TW + 34;
    localparam int GW = (TW + 1 > 33) ? TW + 1 : 33;
    localparam logic [TW-1:0] TICK_MAX = {TW{1'b1}};

    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] k_reg, k_next;
    logic [CW-1:0] i_reg, i_next;
    logic [CW-1:0] j_reg, j_next;
    logic [CW-1:0] sel_reg, sel_next;
    req_type_t     req_reg, req_next;
    logic [7:0]    tag_in_reg, tag_in_next;
    logic [3:0]    pos_in_reg, pos_in_next;
    logic [TW-1:0] per_in_reg, per_in_next;
    logic [TW-1:0] bud_in_reg, bud_in_next;
    logic signed [31:0] delta_reg, delta_next;
    logic [TW-1:0] old_reg, old_next;
    logic [TW-1:0] nb_reg, nb_next;
    logic [TW-1:0] lo_reg, lo_next;
    logic [TW-1:0] hi_reg, hi_next;
    logic [TW-1:0] trial_reg, trial_next;
    logic [TW-1:0] sel_per_reg, sel_per_next;
    logic [TW-1:0] own_reg, own_next;
    logic [TW-1:0] lim_reg, lim_next;
    logic [TW-1:0] cur_reg, cur_next;
    logic [TW-1:0] nxt_reg, nxt_next;
    logic [7:0]    tag_i_reg, tag_i_next;

    logic          out_valid_reg, out_valid_next;
    logic [1:0]    status_reg, status_next;
    logic [3:0]    pos_out_reg, pos_out_next;
    logic [7:0]    tag_out_reg, tag_out_next;
    logic [31:0]   rt_out_reg, rt_out_next;
    logic [32:0]   gd_out_reg, gd_out_next;
    logic          last_reg, last_next;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [RW-1:0] ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [RW-1:0] ram_rdata;
    logic [7:0]    rd_tag;
    logic [TW-1:0] rd_per;
    logic [TW-1:0] rd_bud;

    logic          arith_start;
    logic          arith_done;
    logic [TW-1:0] arith_term;
    logic [TW-1:0] arith_div;
    logic [TW-1:0] arith_mult;

    logic [CW-1:0] k_dec;
    logic [TW:0]   mid_sum;
    logic [TW:0]   acc_sum;
    logic [SW-1:0] nb_sum;
    logic [TW-1:0] nb_clamp;
    logic [TW-1:0] nb_final;
    logic [GW-1:0] gd_diff;
    logic          is_change;
    logic          out_free;

    assign rd_tag = ram_rdata[RW-1 -: 8];
    assign rd_per = ram_rdata[2*TW-1:TW];
    assign rd_bud = ram_rdata[TW-1:0];

    assign is_change = (req_reg == REQ_CHANGE);
    assign k_dec     = k_reg - CW'(1);
    assign mid_sum   = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign acc_sum   = {1'b0, nxt_reg} + {1'b0, arith_term};
    assign nb_sum    = SW'(rd_bud) + {{(SW - 32){delta_reg[31]}}, delta_reg};
    assign nb_final  = (nb_reg < lo_reg) ? nb_reg : lo_reg;
    assign gd_diff   = GW'(nb_reg) - GW'(old_reg);
    assign out_free  = !out_valid_reg || !out_stall;

    // new budget clamped at zero and at the tick range
    always_comb
    begin
        if (nb_sum[SW-1])
        begin
            nb_clamp = '0;
        end
        else if (nb_sum[SW-2:TW] != '0)
        begin
            nb_clamp = TICK_MAX;
        end
        else
        begin
            nb_clamp = nb_sum[TW-1:0];
        end
    end

    assign arith_start = (op == OP_ARITH_START);
    assign arith_div   = (rd_per == '0) ? TW'(1) : rd_per;
    assign arith_mult  = (is_change && j_reg == sel_reg) ? trial_reg : rd_bud;

    fpba_arith #(
        .TW(TW)
    ) u_arith (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (arith_start),
        .dividend (cur_reg),
        .divisor  (arith_div),
        .mult     (arith_mult),
        .done     (arith_done),
        .term     (arith_term)
    );

    fpba_ram #(
        .WIDTH(RW),
        .DEPTH(MAX_SERVERS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // table port
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = AW'(sel_reg);
        ram_wdata = {tag_in_reg, per_in_reg, bud_in_reg};
        ram_raddr = AW'(k_reg);
        case (op)
            OP_RD_KM1:
            begin
                ram_raddr = AW'(k_dec);
            end
            OP_SHIFT_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = AW'(k_reg);
                ram_wdata = ram_rdata;
            end
            OP_ADD_WR:
            begin
                ram_we = 1'b1;
            end
            OP_CHG_WR:
            begin
                ram_we    = 1'b1;
                ram_wdata = {tag_in_reg, sel_per_reg, nb_final};
            end
            OP_SET_RD:
            begin
                ram_raddr = AW'(pos_in_reg);
            end
            OP_SET_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = AW'(pos_in_reg);
                ram_wdata = {rd_tag, rd_per, bud_in_reg};
            end
            OP_RT_RD:
            begin
                ram_raddr = AW'(i_reg);
            end
            OP_RD_J:
            begin
                ram_raddr = AW'(j_reg);
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        cnt_next     = cnt_reg;
        k_next       = k_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        sel_next     = sel_reg;
        req_next     = req_reg;
        tag_in_next  = tag_in_reg;
        pos_in_next  = pos_in_reg;
        per_in_next  = per_in_reg;
        bud_in_next  = bud_in_reg;
        delta_next   = delta_reg;
        old_next     = old_reg;
        nb_next      = nb_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        trial_next   = trial_reg;
        sel_per_next = sel_per_reg;
        own_next     = own_reg;
        lim_next     = lim_reg;
        cur_next     = cur_reg;
        nxt_next     = nxt_reg;
        tag_i_next   = tag_i_reg;
        out_valid_next = out_valid_reg && out_stall;
        status_next  = status_reg;
        pos_out_next = pos_out_reg;
        tag_out_next = tag_out_reg;
        rt_out_next  = rt_out_reg;
        gd_out_next  = gd_out_reg;
        last_next    = last_reg;
        case (op)
            OP_LATCH:
            begin
                req_next    = req_type_t'(req_type);
                tag_in_next = server_tag;
                pos_in_next = position;
                per_in_next = TW'(period);
                bud_in_next = TW'(budget);
                delta_next  = budget_delta;
                k_next      = '0;
            end
            OP_K_INC:
            begin
                k_next = k_reg + CW'(1);
            end
            OP_SEL_K:
            begin
                sel_next = k_reg;
                k_next   = cnt_reg;
            end
            OP_SEL_CNT:
            begin
                sel_next = cnt_reg;
                k_next   = cnt_reg;
            end
            OP_SHIFT_WR:
            begin
                k_next = k_dec;
            end
            OP_ADD_WR:
            begin
                cnt_next = cnt_reg + CW'(1);
            end
            OP_CHG_HIT:
            begin
                sel_next     = k_reg;
                old_next     = rd_bud;
                lo_next      = rd_bud;
                hi_next      = rd_per;
                sel_per_next = rd_per;
                nb_next      = nb_clamp;
            end
            OP_TRY_START:
            begin
                if ({1'b0, lo_reg} + (TW + 1)'(1) == {1'b0, hi_reg})
                begin
                    trial_next = hi_reg;
                end
                else
                begin
                    trial_next = mid_sum[TW:1];
                end
                i_next = sel_reg;
            end
            OP_RT_LOAD:
            begin
                own_next   = (is_change && i_reg == sel_reg) ? trial_reg : rd_bud;
                nxt_next   = (is_change && i_reg == sel_reg) ? trial_reg : rd_bud;
                lim_next   = rd_per;
                tag_i_next = rd_tag;
            end
            OP_RT_ITER:
            begin
                cur_next = nxt_reg;
                nxt_next = own_reg;
                j_next   = '0;
            end
            OP_RT_ACC:
            begin
                nxt_next = acc_sum[TW] ? TICK_MAX : acc_sum[TW-1:0];
                j_next   = j_reg + CW'(1);
            end
            OP_I_INC:
            begin
                i_next = i_reg + CW'(1);
            end
            OP_TRY_OK:
            begin
                lo_next = trial_reg;
            end
            OP_TRY_FAIL:
            begin
                hi_next = (trial_reg == hi_reg) ? lo_reg : trial_reg;
            end
            OP_CHG_WR:
            begin
                nb_next = nb_final;
            end
            OP_SET_WR:
            begin
                tag_i_next = rd_tag;
            end
            OP_RPT_START:
            begin
                i_next = '0;
            end
            OP_EMIT_ADD_FULL:
            begin
                out_valid_next = 1'b1;
                status_next    = STS_FULL;
                pos_out_next   = '0;
                tag_out_next   = tag_in_reg;
                rt_out_next    = '0;
                gd_out_next    = '0;
                last_next      = 1'b1;
            end
            OP_EMIT_ADD:
            begin
                out_valid_next = 1'b1;
                status_next    = STS_OK;
                pos_out_next   = 4'(sel_reg);
                tag_out_next   = tag_in_reg;
                rt_out_next    = '0;
                gd_out_next    = '0;
                last_next      = 1'b1;
            end
            OP_EMIT_CHG_UNK:
            begin
                out_valid_next = 1'b1;
                status_next    = STS_UNKNOWN;
                pos_out_next   = '0;
                tag_out_next   = tag_in_reg;
                rt_out_next    = '0;
                gd_out_next    = '0;
                last_next      = 1'b1;
            end
            OP_EMIT_CHG:
            begin
                out_valid_next = 1'b1;
                status_next    = STS_OK;
                pos_out_next   = 4'(sel_reg);
                tag_out_next   = tag_in_reg;
                rt_out_next    = '0;
                gd_out_next    = gd_diff[32:0];
                last_next      = 1'b1;
            end
            OP_EMIT_SET_UNK:
            begin
                out_valid_next = 1'b1;
                status_next    = STS_UNKNOWN;
                pos_out_next   = pos_in_reg;
                tag_out_next   = '0;
                rt_out_next    = '0;
                gd_out_next    = '0;
                last_next      = 1'b1;
            end
            OP_EMIT_SET:
            begin
                out_valid_next = 1'b1;
                status_next    = STS_OK;
                pos_out_next   = pos_in_reg;
                tag_out_next   = tag_i_reg;
                rt_out_next    = '0;
                gd_out_next    = '0;
                last_next      = 1'b1;
            end
            OP_EMIT_RPT_EMPTY:
            begin
                out_valid_next = 1'b1;
                status_next    = STS_UNKNOWN;
                pos_out_next   = '0;
                tag_out_next   = '0;
                rt_out_next    = '0;
                gd_out_next    = '0;
                last_next      = 1'b1;
            end
            OP_EMIT_RPT:
            begin
                out_valid_next = 1'b1;
                status_next    = STS_OK;
                pos_out_next   = 4'(i_reg);
                tag_out_next   = tag_i_reg;
                rt_out_next    = 32'(nxt_reg);
                gd_out_next    = '0;
                last_next      = sts.rpt_last;
                i_next         = i_reg + CW'(1);
            end
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg       <= k_next;
        i_reg       <= i_next;
        j_reg       <= j_next;
        sel_reg     <= sel_next;
        req_reg     <= req_next;
        tag_in_reg  <= tag_in_next;
        pos_in_reg  <= pos_in_next;
        per_in_reg  <= per_in_next;
        bud_in_reg  <= bud_in_next;
        delta_reg   <= delta_next;
        old_reg     <= old_next;
        nb_reg      <= nb_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        trial_reg   <= trial_next;
        sel_per_reg <= sel_per_next;
        own_reg     <= own_next;
        lim_reg     <= lim_next;
        cur_reg     <= cur_next;
        nxt_reg     <= nxt_next;
        tag_i_reg   <= tag_i_next;
        status_reg  <= status_next;
        pos_out_reg <= pos_out_next;
        tag_out_reg <= tag_out_next;
        rt_out_reg  <= rt_out_next;
        gd_out_reg  <= gd_out_next;
        last_reg    <= last_next;
    end

    always_comb
    begin
        sts.req         = req_reg;
        sts.full        = (cnt_reg == CW'(MAX_SERVERS));
        sts.empty       = (cnt_reg == '0);
        sts.k_at_cnt    = (k_reg == cnt_reg);
        sts.k_at_sel    = (k_reg == sel_reg);
        sts.per_gt      = (rd_per > per_in_reg);
        sts.tag_eq      = (rd_tag == tag_in_reg);
        sts.pos_bad     = ((CW + 4)'(pos_in_reg) >= (CW + 4)'(cnt_reg));
        sts.search_done = (lo_reg >= hi_reg) || (lo_reg >= nb_reg);
        sts.i_at_cnt    = (i_reg == cnt_reg);
        sts.j_at_i      = (j_reg == i_reg);
        sts.arith_done  = arith_done;
        sts.iter_more   = (nxt_reg > cur_reg) && (nxt_reg <= lim_reg);
        sts.rt_fail     = (nxt_reg > lim_reg);
        sts.rpt_last    = ((CW + 1)'(i_reg) + (CW + 1)'(1) == (CW + 1)'(cnt_reg));
        sts.out_free    = out_free;
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign position_res   = pos_out_reg;
    assign server_tag_res = tag_out_reg;
    assign response_time  = rt_out_reg;
    assign granted_delta  = gd_out_reg;
    assign last           = last_reg;

endmodule

`default_nettype wire

/* sv/fpba_ctrl.sv */
// fpba_ctrl: request sequencer of the admission block
// drives one datapath operation a cycle from the datapath status, uses fpba_pkg
`default_nettype none

module fpba_ctrl
    import fpba_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire dp_status_t sts,
    output dp_op_t          op
);

    ctrl_state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (sts.req)
                    REQ_ADD:    state_next = sts.full ? S_ADD_FULL : S_ADD_SCAN;
                    REQ_CHANGE: state_next = S_CHG_SCAN;
                    REQ_SET:    state_next = sts.pos_bad ? S_SET_UNK : S_SET_RD;
                    REQ_REPORT: state_next = sts.empty ? S_RPT_EMPTY : S_RPT_START;
                    default:    state_next = S_IDLE;
                endcase
            end
            S_ADD_SCAN:  state_next = sts.k_at_cnt ? S_SHIFT_RD : S_ADD_CMP;
            S_ADD_CMP:   state_next = sts.per_gt ? S_SHIFT_RD : S_ADD_SCAN;
            S_SHIFT_RD:  state_next = sts.k_at_sel ? S_ADD_WR : S_SHIFT_WR;
            S_SHIFT_WR:  state_next = S_SHIFT_RD;
            S_ADD_WR:    state_next = S_ADD_EMIT;
            S_CHG_SCAN:  state_next = sts.k_at_cnt ? S_CHG_UNK : S_CHG_CMP;
            S_CHG_CMP:   state_next = sts.tag_eq ? S_SRCH : S_CHG_SCAN;
            S_SRCH:      state_next = sts.search_done ? S_CHG_WR : S_TRY_NEXT;
            S_TRY_NEXT:  state_next = sts.i_at_cnt ? S_SRCH : S_RT_LOAD;
            S_RT_LOAD:   state_next = S_RT_ITER;
            S_RT_ITER:   state_next = S_RT_J;
            S_RT_J:      state_next = sts.j_at_i ? S_RT_CHK : S_RT_ARG;
            S_RT_ARG:    state_next = S_RT_WAIT;
            S_RT_WAIT:
            begin
                if (sts.arith_done)
                begin
                    state_next = S_RT_J;
                end
            end
            S_RT_CHK:
            begin
                if (sts.iter_more)
                begin
                    state_next = S_RT_ITER;
                end
                else if (sts.req == REQ_REPORT)
                begin
                    state_next = S_RPT_EMIT;
                end
                else if (sts.rt_fail)
                begin
                    state_next = S_SRCH;
                end
                else
                begin
                    state_next = S_TRY_NEXT;
                end
            end
            S_CHG_WR:    state_next = S_CHG_EMIT;
            S_SET_RD:    state_next = S_SET_WR;
            S_SET_WR:    state_next = S_SET_EMIT;
            S_RPT_START: state_next = S_RPT_NEXT;
            S_RPT_NEXT:  state_next = S_RT_LOAD;
            S_RPT_EMIT:
            begin
                if (sts.out_free)
                begin
                    state_next = sts.rpt_last ? S_IDLE : S_RPT_NEXT;
                end
            end
            S_ADD_FULL, S_ADD_EMIT, S_CHG_UNK, S_CHG_EMIT, S_SET_EMIT, S_SET_UNK,
            S_RPT_EMPTY:
            begin
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        op = OP_NOP;
        case (state_reg)
            S_IDLE:      op = in_valid ? OP_LATCH : OP_NOP;
            S_ADD_SCAN:  op = sts.k_at_cnt ? OP_SEL_CNT : OP_RD_K;
            S_ADD_CMP:   op = sts.per_gt ? OP_SEL_K : OP_K_INC;
            S_SHIFT_RD:  op = sts.k_at_sel ? OP_NOP : OP_RD_KM1;
            S_SHIFT_WR:  op = OP_SHIFT_WR;
            S_ADD_WR:    op = OP_ADD_WR;
            S_ADD_EMIT:  op = sts.out_free ? OP_EMIT_ADD : OP_NOP;
            S_ADD_FULL:  op = sts.out_free ? OP_EMIT_ADD_FULL : OP_NOP;
            S_CHG_SCAN:  op = sts.k_at_cnt ? OP_NOP : OP_RD_K;
            S_CHG_CMP:   op = sts.tag_eq ? OP_CHG_HIT : OP_K_INC;
            S_CHG_UNK:   op = sts.out_free ? OP_EMIT_CHG_UNK : OP_NOP;
            S_SRCH:      op = sts.search_done ? OP_NOP : OP_TRY_START;
            S_TRY_NEXT:  op = sts.i_at_cnt ? OP_TRY_OK : OP_RT_RD;
            S_RT_LOAD:   op = OP_RT_LOAD;
            S_RT_ITER:   op = OP_RT_ITER;
            S_RT_J:      op = sts.j_at_i ? OP_NOP : OP_RD_J;
            S_RT_ARG:    op = OP_ARITH_START;
            S_RT_WAIT:   op = sts.arith_done ? OP_RT_ACC : OP_NOP;
            S_RT_CHK:
            begin
                if (sts.iter_more || sts.req == REQ_REPORT)
                begin
                    op = OP_NOP;
                end
                else if (sts.rt_fail)
                begin
                    op = OP_TRY_FAIL;
                end
                else
                begin
                    op = OP_I_INC;
                end
            end
            S_CHG_WR:    op = OP_CHG_WR;
            S_CHG_EMIT:  op = sts.out_free ? OP_EMIT_CHG : OP_NOP;
            S_SET_RD:    op = OP_SET_RD;
            S_SET_WR:    op = OP_SET_WR;
            S_SET_EMIT:  op = sts.out_free ? OP_EMIT_SET : OP_NOP;
            S_SET_UNK:   op = sts.out_free ? OP_EMIT_SET_UNK : OP_NOP;
            S_RPT_EMPTY: op = sts.out_free ? OP_EMIT_RPT_EMPTY : OP_NOP;
            S_RPT_START: op = OP_RPT_START;
            S_RPT_NEXT:  op = OP_RT_RD;
            S_RPT_EMIT:  op = sts.out_free ? OP_EMIT_RPT : OP_NOP;
            default:     op = OP_NOP;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

endmodule

`default_nettype wire

/* sv/fixed_priority_budget_admission.sv */
// fixed_priority_budget_admission: top level, rate-monotonic server table with admission
// joins fpba_ctrl and fpba_dp, uses fpba_pkg
`default_nettype none

// Takes one request at a time; in_stall stays high until the request's last result is
// loaded into the output register, which then waits for the consumer while the next
// request is accepted. The table sits in one ram read one row a cycle. An add scans the
// entries for its place and shifts every entry behind it up one row; a set reads and
// rewrites one row. Every response-time iteration computes one term per higher-priority
// entry in the shared serial divide-and-multiply unit, so a report grows with the square
// of the server count times the iterations, and a budget change runs up to TICK_WIDTH+1
// binary search trials, each analysing the changed server and every server below it.
module fixed_priority_budget_admission
    import fpba_pkg::*;
#(
    parameter int MAX_SERVERS = MAX_SERVERS_DEF,
    parameter int TICK_WIDTH  = TICK_WIDTH_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [1:0]         req_type,
    input  wire logic [7:0]         server_tag,
    input  wire logic [3:0]         position,
    input  wire logic [31:0]        period,
    input  wire logic [31:0]        budget,
    input  wire logic signed [31:0] budget_delta,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [1:0]              status,
    output logic [3:0]              position_res,
    output logic [7:0]              server_tag_res,
    output logic [31:0]             response_time,
    output logic signed [32:0]      granted_delta,
    output logic                    last
);

    dp_op_t     op;
    dp_status_t sts;

    fpba_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .op       (op)
    );

    fpba_dp #(
        .MAX_SERVERS (MAX_SERVERS),
        .TICK_WIDTH  (TICK_WIDTH)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .op             (op),
        .sts            (sts),
        .req_type       (req_type),
        .server_tag     (server_tag),
        .position       (position),
        .period         (period),
        .budget         (budget),
        .budget_delta   (budget_delta),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .position_res   (position_res),
        .server_tag_res (server_tag_res),
        .response_time  (response_time),
        .granted_delta  (granted_delta),
        .last           (last)
    );

endmodule

`default_nettype wire

/* sv/fpba_checker.sv */
// fpba_checker: port-level assertions for the admission block, bound to the top level
// uses fpba_pkg status codes
`default_nettype none

module fpba_checker
    import fpba_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_valid,
    input wire logic               in_stall,
    input wire logic [1:0]         req_type,
    input wire logic [7:0]         server_tag,
    input wire logic [3:0]         position,
    input wire logic [31:0]        period,
    input wire logic [31:0]        budget,
    input wire logic signed [31:0] budget_delta,
    input wire logic               out_valid,
    input wire logic               out_stall,
    input wire logic [1:0]         status,
    input wire logic [3:0]         position_res,
    input wire logic [7:0]         server_tag_res,
    input wire logic [31:0]        response_time,
    input wire logic signed [32:0] granted_delta,
    input wire logic               last
);

    // one request at a time
    a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("request accepted while another is in progress");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(last)
            && $stable(response_time) && $stable(granted_delta))
        else $error("stalled result changed");

    a_full_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == STS_FULL |-> last && position_res == 4'd0
            && response_time == 32'd0 && granted_delta == 33'sd0)
        else $error("table full result malformed");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != STS_OK |-> last && granted_delta == 33'sd0
            && response_time == 32'd0)
        else $error("rejected request carries data");

endmodule

bind fixed_priority_budget_admission fpba_checker u_fpba_checker (.*);

`default_nettype wire

/* bench/fixed_priority_budget_admission_tb.sv */
// fixed_priority_budget_admission_tb: self-checking bench for the rate-monotonic budget admission block
// predicts each result from its own copy of the server table; needs fpba_pkg and the top level
`timescale 1ns / 1ps

module fixed_priority_budget_admission_tb
    import fpba_pkg::*;
();

    localparam longint unsigned TICK_ALL = 64'hFFFF_FFFF;
    localparam int NSRV = MAX_SERVERS_DEF;
    localparam longint CYCLE_LIMIT = 40_000_000;

    typedef struct {
        logic [1:0]  st;
        logic [3:0]  pos;
        logic [7:0]  tag;
        logic [31:0] rt;
        logic [32:0] gd;
        logic        lst;
    } admission_result_t;

    class admission_scoreboard;
        longint unsigned srv_period [NSRV];
        longint unsigned srv_budget [NSRV];
        logic [7:0]      srv_tag [NSRV];
        int              srv_count;
        admission_result_t awaited [$];
        int              errors;

        function void report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endfunction

        function void push(logic [1:0] st, int pos, logic [7:0] tag,
                           longint unsigned rt, longint gd, logic lst);
            admission_result_t r;
            r.st = st;
            r.pos = pos[3:0];
            r.tag = tag;
            r.rt = rt[31:0];
            r.gd = gd[32:0];
            r.lst = lst;
            awaited.insert(awaited.size(), r);
        endfunction

        function longint unsigned response_of(int i);
            longint unsigned own, lim, cur, nxt, p, q, c, term, s;
            own = srv_budget[i];
            lim = srv_period[i];
            nxt = own;
            do
            begin
                cur = nxt;
                nxt = own;
                for (int j = 0; j < i; j++)
                begin
                    p = (srv_period[j] != 0) ? srv_period[j] : 1;
                    q = srv_budget[j];
                    c = cur / p + ((cur % p) != 0);
                    term = (q != 0 && c > TICK_ALL / q) ? TICK_ALL : c * q;
                    s = nxt + term;
                    nxt = (s > TICK_ALL) ? TICK_ALL : s;
                end
            end
            while (nxt > cur && nxt <= lim);
            return nxt;
        endfunction

        function bit fits(int i, longint unsigned b);
            longint unsigned keep;
            bit ok;
            keep = srv_budget[i];
            srv_budget[i] = b;
            ok = response_of(i) <= srv_period[i];
            for (int j = i + 1; ok && j < srv_count; j++)
                ok = response_of(j) <= srv_period[j];
            srv_budget[i] = keep;
            return ok;
        endfunction

        function longint unsigned budget_cap(int i);
            longint unsigned lo, hi, mid;
            lo = srv_budget[i];
            hi = srv_period[i];
            if (lo >= hi)
                return lo;
            while (hi > lo + 1)
            begin
                mid = (lo + hi) / 2;
                if (fits(i, mid))
                    lo = mid;
                else
                    hi = mid;
            end
            if (hi == lo)
                return lo;
            return fits(i, hi) ? hi : lo;
        endfunction

        function void note_request(req_type_t req, logic [7:0] tag, logic [3:0] pos,
                                   logic [31:0] per, logic [31:0] bud,
                                   logic signed [31:0] delta);
            int k;
            longint nb, cur, cap;
            case (req)
                REQ_ADD:
                begin
                    if (srv_count >= NSRV)
                        push(STS_FULL, 0, tag, 0, 0, 1);
                    else
                    begin
                        k = 0;
                        while (k < srv_count && srv_period[k] <= per)
                            k++;
                        for (int m = srv_count; m > k; m--)
                        begin
                            srv_period[m] = srv_period[m - 1];
                            srv_budget[m] = srv_budget[m - 1];
                            srv_tag[m] = srv_tag[m - 1];
                        end
                        srv_period[k] = 64'(per);
                        srv_budget[k] = 64'(bud);
                        srv_tag[k] = tag;
                        srv_count++;
                        push(STS_OK, k, tag, 0, 0, 1);
                    end
                end
                REQ_CHANGE:
                begin
                    k = 0;
                    while (k < srv_count && srv_tag[k] != tag)
                        k++;
                    if (k >= srv_count)
                        push(STS_UNKNOWN, 0, tag, 0, 0, 1);
                    else
                    begin
                        cur = srv_budget[k];
                        nb = cur + longint'(delta);
                        if (nb < 0)
                            nb = 0;
                        if (nb > longint'(TICK_ALL))
                            nb = TICK_ALL;
                        cap = budget_cap(k);
                        if (nb > cap)
                            nb = cap;
                        srv_budget[k] = nb;
                        push(STS_OK, k, tag, 0, nb - cur, 1);
                    end
                end
                REQ_SET:
                begin
                    if (pos >= srv_count)
                        push(STS_UNKNOWN, int'(pos), 0, 0, 0, 1);
                    else
                    begin
                        srv_budget[pos] = 64'(bud);
                        push(STS_OK, int'(pos), srv_tag[pos], 0, 0, 1);
                    end
                end
                default:
                begin
                    if (srv_count == 0)
                        push(STS_UNKNOWN, 0, 0, 0, 0, 1);
                    for (int m = 0; m < srv_count; m++)
                        push(STS_OK, m, srv_tag[m], response_of(m), 0, m + 1 == srv_count);
                end
            endcase
        endfunction

        function void check_result(admission_result_t got);
            admission_result_t w;
            if (awaited.size() == 0)
            begin
                report($sformatf("unexpected result tag %0d pos %0d", got.tag, got.pos));
                return;
            end
            w = awaited.pop_front();
            if (got.st !== w.st)
                report($sformatf("status %0d, want %0d", got.st, w.st));
            if (got.pos !== w.pos)
                report($sformatf("position %0d, want %0d", got.pos, w.pos));
            if (got.tag !== w.tag)
                report($sformatf("tag %0d, want %0d", got.tag, w.tag));
            if (got.rt !== w.rt)
                report($sformatf("response time %0d, want %0d", got.rt, w.rt));
            if (got.gd !== w.gd)
                report($sformatf("granted delta %h, want %h", got.gd, w.gd));
            if (got.lst !== w.lst)
                report($sformatf("last %b, want %b", got.lst, w.lst));
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [1:0]         req_type = '0;
    logic [7:0]         server_tag = '0;
    logic [3:0]         position = '0;
    logic [31:0]        period = '0;
    logic [31:0]        budget = '0;
    logic signed [31:0] budget_delta = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [1:0]         status;
    logic [3:0]         position_res;
    logic [7:0]         server_tag_res;
    logic [31:0]        response_time;
    logic signed [32:0] granted_delta;
    logic               last;

    admission_scoreboard sb = new();
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    longint cycles = 0;

    fixed_priority_budget_admission i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .req_type(req_type), .server_tag(server_tag), .position(position),
        .period(period), .budget(budget), .budget_delta(budget_delta),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .position_res(position_res), .server_tag_res(server_tag_res),
        .response_time(response_time), .granted_delta(granted_delta), .last(last)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        admission_result_t got;
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("fixed_priority_budget_admission regression: fail");
            $finish;
        end
        if (rst_n && out_valid && !out_stall)
        begin
            got.st = status;
            got.pos = position_res;
            got.tag = server_tag_res;
            got.rt = response_time;
            got.gd = granted_delta;
            got.lst = last;
            sb.check_result(got);
        end
        out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    task send_request(req_type_t req, logic [7:0] tag, logic [3:0] pos,
                      logic [31:0] per, logic [31:0] bud, logic signed [31:0] delta);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= req;
        server_tag <= tag;
        position <= pos;
        period <= per;
        budget <= bud;
        budget_delta <= delta;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_request(req, tag, pos, per, bud, delta);
    endtask

    task drain;
        in_valid <= 1'b0;
        while (sb.awaited.size() != 0)
            @(posedge clk);
    endtask

    // random request over a small table of short periods; the huge-period server is left alone
    task random_request;
        int r;
        int p;
        logic [7:0] t;
        logic [3:0] q;
        logic signed [31:0] d;
        r = $urandom_range(99);
        if (sb.srv_count < 7 && r < 25)
        begin
            p = $urandom_range(1, 48);
            send_request(REQ_ADD, 8'($urandom_range(1, 200)), '0, p,
                         $urandom_range(0, p / 3), $urandom);
        end
        else if (r < 65)
        begin
            if ($urandom_range(99) < 80 && sb.srv_count > 0)
                t = sb.srv_tag[$urandom_range(0, sb.srv_count - 1)];
            else
                t = 8'($urandom_range(0, 254));
            if (t == 8'hFF)
                t = 8'd0;
            d = ($urandom_range(3) == 0) ? $urandom : $urandom_range(0, 40) - 20;
            send_request(REQ_CHANGE, t, 4'($urandom), $urandom, $urandom, d);
        end
        else if (r < 85)
        begin
            q = 4'($urandom_range(0, 15));
            if (q < sb.srv_count && sb.srv_tag[q] == 8'hFF)
                q = 4'd15;
            send_request(REQ_SET, 8'($urandom), q, $urandom, $urandom_range(0, 8), $urandom);
        end
        else
            send_request(REQ_REPORT, 8'($urandom), 4'($urandom), $urandom, $urandom,
                         $urandom);
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(REQ_REPORT, 0, 0, 0, 0, 0);
        send_request(REQ_CHANGE, 8'd5, 0, 0, 0, 32'sd7);
        send_request(REQ_SET, 0, 4'd0, 0, 32'd9, 0);
        send_request(REQ_ADD, 8'hFF, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
        send_request(REQ_ADD, 8'd0, 4'hF, 32'd0, 32'd0, 0);
        send_request(REQ_ADD, 8'd10, 0, 32'd20, 32'd3, 0);
        send_request(REQ_ADD, 8'd11, 0, 32'd20, 32'd4, 0);
        send_request(REQ_ADD, 8'd12, 0, 32'd50, 32'd5, 0);
        send_request(REQ_CHANGE, 8'd10, 0, 0, 0, 32'sh7FFF_FFFF);
        send_request(REQ_CHANGE, 8'd11, 0, 0, 0, 32'sh8000_0000);
        send_request(REQ_CHANGE, 8'd0, 0, 0, 0, 32'sd5);
        send_request(REQ_SET, 0, 4'd2, 0, 32'd6, 0);
        send_request(REQ_SET, 0, 4'd9, 0, 32'd1, 0);
        send_request(REQ_CHANGE, 8'd12, 0, 0, 0, 32'sd3);
        send_request(REQ_REPORT, 0, 0, 0, 0, 0);
        send_request(REQ_ADD, 8'd10, 0, 32'd30, 32'd2, 0);
        send_request(REQ_CHANGE, 8'd10, 0, 0, 0, -32'sd1);
        send_request(REQ_REPORT, 0, 0, 0, 0, 0);
        drain();

        send_idle_pct = 20;
        recv_idle_pct = 71;
        for (int n = 0; n < 100; n++)
            random_request();
        drain();
        send_idle_pct = 71;
        recv_idle_pct = 20;
        for (int n = 0; n < 100; n++)
            random_request();
        drain();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int n = 0; n < 80; n++)
            random_request();

        // fill the table with zero budgets, then run into the full case
        while (sb.srv_count < NSRV)
            send_request(REQ_ADD, 8'($urandom_range(1, 200)), 0, $urandom_range(1, 48), 0, 0);
        send_request(REQ_ADD, 8'd77, 0, 32'd5, 32'd1, 0);
        send_request(REQ_SET, 0, 4'd15, 0, 32'd0, 0);
        send_request(REQ_CHANGE, sb.srv_tag[1], 0, 0, 0, 32'sd2);
        send_request(REQ_REPORT, 0, 0, 0, 0, 0);
        drain();
        repeat (50) @(posedge clk);

        if (sb.errors == 0)
            $display("fixed_priority_budget_admission regression: pass");
        else
            $display("fixed_priority_budget_admission regression: fail");
        $finish;
    end

endmodule

/* files.f */
sv/fpba_pkg.sv
sv/fpba_ram.sv
sv/fpba_arith.sv
sv/fpba_dp.sv
sv/fpba_ctrl.sv
sv/fixed_priority_budget_admission.sv
sv/fpba_checker.sv
bench/fixed_priority_budget_admission_tb.sv
